// ----- hw/rtl/bmlg_pkg.sv -----
// ----------------------------------------------------------------------------
// bmlg_pkg
// shared types and constants for the bounded multi-kind random generator
// ----------------------------------------------------------------------------
package bmlg_pkg;

    // item modes
    localparam logic [1:0] MODE_DRAW  = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_SPLIT = 2'd2;

    // generator kinds
    localparam logic [2:0] KIND_MINSTD   = 3'd0;
    localparam logic [2:0] KIND_LEHMER16 = 3'd1;
    localparam logic [2:0] KIND_RAND     = 3'd2;
    localparam logic [2:0] KIND_RANDU    = 3'd3;
    localparam logic [2:0] KIND_WEYL     = 3'd4;

    // arithmetic constants
    localparam logic [31:0] MINSTD_MOD  = 32'h7FFF_FFFF;
    localparam logic [31:0] MINSTD_MULT = 32'd48271;
    localparam logic [31:0] LEHMER_MULT = 32'd75;
    localparam logic [17:0] LEHMER_MOD  = 18'd65537;
    localparam logic [31:0] RAND_MULT   = 32'd1103515245;
    localparam logic [31:0] RAND_INC    = 32'd12345;
    localparam logic [31:0] RANDU_MULT  = 32'd65539;
    localparam logic [31:0] WEYL_INC    = 32'd362437;

    // divider iteration counts
    localparam logic [5:0] DIV_ITERS_MOD   = 6'd32;
    localparam logic [5:0] DIV_ITERS_RANDU = 6'd31;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_FOLD,
        ST_SCALE,
        ST_POST,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic        start;
        logic [30:0] rem_init;
        logic [31:0] dividend;
        logic [30:0] divisor;
        logic [5:0]  iters;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
        logic [30:0] remainder;
    } div_rsp_t;

    // main seed must stay away from the two fixed points
    function automatic logic [31:0] fix_main(input logic [31:0] s);
        logic [31:0] r;
        r = s;
        if (s == 32'd0 || s == MINSTD_MOD) begin
            r = 32'd1;
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/bounded_multi_lcg_generator_unit.sv -----
// ----------------------------------------------------------------------------
// bounded_multi_lcg_generator_unit
// five-kind seeded generator giving bounded draws, seed loads and child splits
// ----------------------------------------------------------------------------
//  channel  | ports                                   | dir | item
//  ---------+-----------------------------------------+-----+----------------------
//  input    | s_valid s_ready s_mode s_bound s_seed.. | in  | one request
//  result   | m_valid m_ready m_value m_child_*       | out | one result per request
//  config   | cfg_valid cfg_ready cfg_data            | in  | generator kind
//
//  draws of kinds 0, 1 and 4 step through multiply, fold, 32 divider passes plus
//  the done step, hand-off, idle; kind 3 adds scaling and a set-up step with 31
//  passes; kind 2 runs multiply, fold, scaling, set-up, hand-off; splits, zero-bound
//  and dead-seed draws go from fold to hand-off; loads and unused modes to hand-off
//  s_ready and cfg_ready are high only while the sequencer is idle; a finished
//  result waits in the output register, so the next item is taken while m_ready
//  is low; reset (synchronous, active low) gives kind 0, main seed 1, aux seed 0
// ----------------------------------------------------------------------------
module bounded_multi_lcg_generator_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [30:0] s_bound,
    input  logic [63:0] s_seed_value,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [30:0] m_value,
    output logic [31:0] m_child_main,
    output logic [31:0] m_child_aux,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_data
);
    import bmlg_pkg::*;

    // sequencer and architectural state
    state_t      state_reg, state_next;
    logic [2:0]  kind_reg, kind_next;
    logic [31:0] main_seed_reg, main_seed_next;
    logic [31:0] aux_seed_reg, aux_seed_next;

    // item in flight
    logic [1:0]  mode_reg, mode_next;
    logic [30:0] bound_reg, bound_next;
    logic [63:0] prod_reg, prod_next;
    logic [30:0] value_res_reg, value_res_next;
    logic [31:0] cmain_res_reg, cmain_res_next;
    logic [31:0] caux_res_reg, caux_res_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [30:0] m_value_reg, m_value_next;
    logic [31:0] m_child_main_reg, m_child_main_next;
    logic [31:0] m_child_aux_reg, m_child_aux_next;

    // shared multiplier operands
    logic [31:0] mul_a, mul_b;

    // seed fold of the registered product
    logic [31:0] ms_sum, ms_res;
    logic [15:0] lh_lo;
    logic [6:0]  lh_hi;
    logic [16:0] lh_t;
    logic [17:0] lh_wrap;
    logic [31:0] fold_seed;
    logic [31:0] split_aux;

    div_req_t    div_req;
    div_rsp_t    div_rsp;

    logic        s_accept;

    assign s_accept  = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);

    // shared divider: modulo by the bound, or the randu scaling by 2^31-1
    bmlg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // multiplier operand select: seed step first, then the scaling multiply
    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        if (state_reg == ST_MUL) begin
            case (kind_reg)
                KIND_MINSTD: begin
                    mul_a = main_seed_reg;
                    mul_b = MINSTD_MULT;
                end
                KIND_LEHMER16: begin
                    mul_a = 32'({1'b0, main_seed_reg[15:0]} + 17'd1);
                    mul_b = LEHMER_MULT;
                end
                KIND_RAND: begin
                    mul_a = main_seed_reg;
                    mul_b = RAND_MULT;
                end
                KIND_RANDU: begin
                    mul_a = main_seed_reg;
                    mul_b = RANDU_MULT;
                end
                default: begin
                    mul_a = 32'd0;
                    mul_b = 32'd0;
                end
            endcase
        end else if (state_reg == ST_SCALE) begin
            mul_a = {1'b0, bound_reg};
            if (kind_reg == KIND_RAND) begin
                mul_b = {17'd0, main_seed_reg[30:16]};
            end else begin
                // randu: seed is known nonzero here, so s-1 fits 31 bits
                mul_b = {1'b0, main_seed_reg[30:0] - 31'd1};
            end
        end
    end

    // reduce the product into the new main seed
    always_comb begin
        // mod 2^31-1: fold the high part onto the low part, then one subtract
        ms_sum = 32'(prod_reg[47:31]) + 32'(prod_reg[30:0]);
        ms_res = (ms_sum >= MINSTD_MOD) ? ms_sum - MINSTD_MOD : ms_sum;

        // mod 65537: 2^16 is -1, so take low minus high and wrap
        lh_lo   = prod_reg[15:0];
        lh_hi   = prod_reg[22:16];
        lh_wrap = 18'(lh_lo) + LEHMER_MOD - 18'(lh_hi);
        if (lh_lo >= 16'(lh_hi)) begin
            lh_t = 17'(lh_lo - 16'(lh_hi));
        end else begin
            lh_t = lh_wrap[16:0];
        end

        case (kind_reg)
            KIND_MINSTD:   fold_seed = ms_res;
            KIND_LEHMER16: fold_seed = 32'(lh_t) - 32'd1;
            KIND_RAND:     fold_seed = prod_reg[31:0] + RAND_INC;
            KIND_RANDU:    fold_seed = {1'b0, prod_reg[30:0]};
            KIND_WEYL:     fold_seed = main_seed_reg + WEYL_INC;
            default:       fold_seed = main_seed_reg;
        endcase

        split_aux = aux_seed_reg ^ fold_seed;
    end

    // sequencer
    always_comb begin
        state_next        = state_reg;
        kind_next         = kind_reg;
        main_seed_next    = main_seed_reg;
        aux_seed_next     = aux_seed_reg;
        mode_next         = mode_reg;
        bound_next        = bound_reg;
        prod_next         = prod_reg;
        value_res_next    = value_res_reg;
        cmain_res_next    = cmain_res_reg;
        caux_res_next     = caux_res_reg;
        m_value_next      = m_value_reg;
        m_child_main_next = m_child_main_reg;
        m_child_aux_next  = m_child_aux_reg;
        m_valid_next      = m_valid_reg && !m_ready;

        div_req.start    = 1'b0;
        div_req.rem_init = 31'd0;
        div_req.dividend = fold_seed;
        div_req.divisor  = bound_reg;
        div_req.iters    = DIV_ITERS_MOD;

        // config is written only while idle
        if (cfg_valid && cfg_ready) begin
            kind_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    mode_next      = s_mode;
                    bound_next     = s_bound;
                    value_res_next = 31'd0;
                    cmain_res_next = 32'd0;
                    caux_res_next  = 32'd0;
                    case (s_mode)
                        MODE_DRAW, MODE_SPLIT: begin
                            state_next = ST_MUL;
                        end
                        MODE_LOAD: begin
                            main_seed_next = fix_main(s_seed_value[31:0]);
                            aux_seed_next  = s_seed_value[31:0] ^ s_seed_value[63:32];
                            state_next     = ST_OUT;
                        end
                        default: begin
                            // unused mode: zeros, no state change
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end

            ST_MUL: begin
                prod_next  = mul_a * mul_b;
                state_next = ST_FOLD;
            end

            ST_FOLD: begin
                main_seed_next = fold_seed;
                state_next     = ST_OUT;
                if (mode_reg == MODE_SPLIT) begin
                    aux_seed_next  = split_aux;
                    cmain_res_next = fix_main(split_aux);
                    caux_res_next  = ~split_aux;
                end else begin
                    case (kind_reg)
                        KIND_MINSTD, KIND_LEHMER16, KIND_WEYL: begin
                            // zero bound leaves the value at zero
                            if (bound_reg != 31'd0) begin
                                div_req.start = 1'b1;
                                state_next    = ST_DIV;
                            end
                        end
                        KIND_RAND: begin
                            state_next = ST_SCALE;
                        end
                        KIND_RANDU: begin
                            // a zero seed saturates the value at zero
                            if (fold_seed != 32'd0) begin
                                state_next = ST_SCALE;
                            end
                        end
                        default: begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end

            ST_SCALE: begin
                prod_next  = mul_a * mul_b;
                state_next = ST_POST;
            end

            ST_POST: begin
                if (kind_reg == KIND_RAND) begin
                    value_res_next = prod_reg[45:15];
                    state_next     = ST_OUT;
                end else begin
                    // product / (2^31-1): high bits seed the remainder
                    div_req.start    = 1'b1;
                    div_req.rem_init = prod_reg[61:31];
                    div_req.dividend = {prod_reg[30:0], 1'b0};
                    div_req.divisor  = MINSTD_MOD[30:0];
                    div_req.iters    = DIV_ITERS_RANDU;
                    state_next       = ST_DIV;
                end
            end

            ST_DIV: begin
                if (div_rsp.done) begin
                    if (kind_reg == KIND_RANDU) begin
                        value_res_next = div_rsp.quotient[30:0];
                    end else begin
                        value_res_next = div_rsp.remainder;
                    end
                    state_next = ST_OUT;
                end
            end

            ST_OUT: begin
                // hand over once the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next      = 1'b1;
                    m_value_next      = value_res_reg;
                    m_child_main_next = cmain_res_reg;
                    m_child_aux_next  = caux_res_reg;
                    state_next        = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            kind_reg      <= KIND_MINSTD;
            main_seed_reg <= 32'd1;
            aux_seed_reg  <= 32'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            main_seed_reg <= main_seed_next;
            aux_seed_reg  <= aux_seed_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        mode_reg         <= mode_next;
        bound_reg        <= bound_next;
        prod_reg         <= prod_next;
        value_res_reg    <= value_res_next;
        cmain_res_reg    <= cmain_res_next;
        caux_res_reg     <= caux_res_next;
        m_value_reg      <= m_value_next;
        m_child_main_reg <= m_child_main_next;
        m_child_aux_reg  <= m_child_aux_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_value      = m_value_reg;
    assign m_child_main = m_child_main_reg;
    assign m_child_aux  = m_child_aux_reg;

    // divider finishes only while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("divider result outside the divide step");

    // minimal-standard step keeps the seed below 2^31-1
    a_minstd_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FOLD && kind_reg == KIND_MINSTD) |=>
        (main_seed_reg < MINSTD_MOD))
        else $error("minimal-standard seed out of range");

    // a modulo draw lands below its bound
    a_value_below_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && mode_reg == MODE_DRAW && bound_reg != 31'd0 &&
         (kind_reg == KIND_MINSTD || kind_reg == KIND_LEHMER16 ||
          kind_reg == KIND_WEYL)) |-> (value_res_reg < bound_reg))
        else $error("drawn value not below bound");

    // a result appears only from the hand-off step
    a_valid_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("result raised outside hand-off");

endmodule

// ----- hw/rtl/bmlg_div.sv -----
// ----------------------------------------------------------------------------
// bmlg_div
// radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bmlg_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  bmlg_pkg::div_req_t  req,
    output bmlg_pkg::div_rsp_t  rsp
);
    import bmlg_pkg::*;

    logic [30:0] rem_reg,  rem_next;
    logic [31:0] dvd_reg,  dvd_next;
    logic [31:0] quo_reg,  quo_next;
    logic [30:0] dsr_reg,  dsr_next;
    logic [5:0]  cnt_reg,  cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    logic [31:0] trial;
    logic [32:0] diff;
    logic        ge;

    assign trial = {rem_reg, dvd_reg[31]};
    assign diff  = {1'b0, trial} - {2'b00, dsr_reg};
    assign ge    = ~diff[32];

    always_comb begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = req.rem_init;
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
            quo_next  = 32'd0;
            cnt_next  = req.iters;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? diff[30:0] : trial[30:0];
            dvd_next = {dvd_reg[30:0], 1'b0};
            quo_next = {quo_reg[30:0], ge};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule
